@@ rtl/slpg_pkg.sv @@
// ----------------------------------------------------------------------------
// slpg_pkg: shared types and constants of the status LED pattern generator
// Holds the command codes, status numbers, colour codes, the time phase
// widths and the state and result structures passed between the modules.
// ----------------------------------------------------------------------------
package slpg_pkg;

  // Command codes of an input request.
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_SET   = 3'd1;
  localparam logic [2:0] CMD_CLEAR = 3'd2;
  localparam logic [2:0] CMD_FLASH = 3'd3;
  localparam logic [2:0] CMD_QUERY = 3'd4;

  // Status numbers.
  localparam int unsigned NUM_STATUS = 14;
  localparam logic [3:0] ST_OFF        = 4'd0;
  localparam logic [3:0] ST_BOOT       = 4'd1;
  localparam logic [3:0] ST_SETUP      = 4'd2;
  localparam logic [3:0] ST_WIFI       = 4'd3;
  localparam logic [3:0] ST_UNCLAIMED  = 4'd4;
  localparam logic [3:0] ST_DISARMED   = 4'd5;
  localparam logic [3:0] ST_ARMED      = 4'd6;
  localparam logic [3:0] ST_OFFLINE    = 4'd7;
  localparam logic [3:0] ST_AUTH_FAIL  = 4'd8;
  localparam logic [3:0] ST_DETECTION  = 4'd9;
  localparam logic [3:0] ST_CAMERA     = 4'd10;
  localparam logic [3:0] ST_SERVO      = 4'd11;
  localparam logic [3:0] ST_LASER      = 4'd12;
  localparam logic [3:0] ST_ERROR      = 4'd13;

  // Colour codes.
  localparam logic [2:0] C_OFF    = 3'd0;
  localparam logic [2:0] C_RED    = 3'd1;
  localparam logic [2:0] C_GREEN  = 3'd2;
  localparam logic [2:0] C_BLUE   = 3'd3;
  localparam logic [2:0] C_YELLOW = 3'd4;
  localparam logic [2:0] C_ORANGE = 3'd5;
  localparam logic [2:0] C_CYAN   = 3'd6;
  localparam logic [2:0] C_WHITE  = 3'd7;

  // Pattern periods in milliseconds; all divide the 60000 ms wrap.
  localparam int unsigned PER_400  = 400;
  localparam int unsigned PER_500  = 500;
  localparam int unsigned PER_1000 = 1000;
  localparam int unsigned PER_1250 = 1250;
  localparam int unsigned PER_1500 = 1500;
  localparam int unsigned PER_2000 = 2000;
  localparam int unsigned PER_3000 = 3000;
  localparam int unsigned PER_4000 = 4000;
  localparam int unsigned PER_5000 = 5000;

  localparam logic [7:0] FLASH_LEN_RESET = 8'd200;
  localparam logic [7:0] FULL_BRIGHT     = 8'd255;

  // Reciprocal multipliers for the breathing ramps:
  // d*255/1000 == (d*4278237) >> 24 for d <= 1000,
  // d*255/1500 == (d*178262)  >> 20 for d <= 1500.
  localparam logic [31:0] BOOT_RECIP  = 32'd4278237;
  localparam logic [28:0] SETUP_RECIP = 29'd178262;

  typedef logic [8:0]  ph400_t;
  typedef logic [8:0]  ph500_t;
  typedef logic [9:0]  ph1000_t;
  typedef logic [10:0] ph1250_t;
  typedef logic [10:0] ph1500_t;
  typedef logic [10:0] ph2000_t;
  typedef logic [11:0] ph3000_t;
  typedef logic [11:0] ph4000_t;
  typedef logic [12:0] ph5000_t;

  // Status mask, flash countdown and the time as one phase per period.
  typedef struct packed {
    logic [NUM_STATUS-1:0] mask;
    logic [7:0]            flash;
    ph400_t                t400;
    ph500_t                t500;
    ph1000_t               t1000;
    ph1250_t               t1250;
    ph1500_t               t1500;
    ph2000_t               t2000;
    ph3000_t               t3000;
    ph4000_t               t4000;
    ph5000_t               t5000;
  } slpg_state_t;

  // One result item.
  typedef struct packed {
    logic [3:0] shown_state;
    logic [2:0] color_code;
    logic [7:0] brightness;
    logic       queried_active;
  } slpg_result_t;

endpackage

@@ rtl/slpg_state.sv @@
// ----------------------------------------------------------------------------
// slpg_state: status mask, flash countdown and millisecond phase counters
// Applies one command to the stored state. The state after the command is
// offered to the pattern logic and is stored when the request is accepted.
// ----------------------------------------------------------------------------
module slpg_state (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata,
  input  logic                 accept,
  input  logic [2:0]           command,
  input  logic [3:0]           state_id,
  output slpg_pkg::slpg_state_t st_nxt
);
  import slpg_pkg::*;

  slpg_state_t st_r;
  logic [7:0]  flash_len_r;
  slpg_state_t tick_st;
  logic        id_ok;

  // Time advanced by one millisecond; every phase wraps at its own period and a running flash countdown drops by one.
  always_comb begin
    tick_st       = st_r;
    tick_st.t400  = (st_r.t400  == ph400_t'(PER_400 - 1))   ? '0 : st_r.t400  + 9'd1;
    tick_st.t500  = (st_r.t500  == ph500_t'(PER_500 - 1))   ? '0 : st_r.t500  + 9'd1;
    tick_st.t1000 = (st_r.t1000 == ph1000_t'(PER_1000 - 1)) ? '0 : st_r.t1000 + 10'd1;
    tick_st.t1250 = (st_r.t1250 == ph1250_t'(PER_1250 - 1)) ? '0 : st_r.t1250 + 11'd1;
    tick_st.t1500 = (st_r.t1500 == ph1500_t'(PER_1500 - 1)) ? '0 : st_r.t1500 + 11'd1;
    tick_st.t2000 = (st_r.t2000 == ph2000_t'(PER_2000 - 1)) ? '0 : st_r.t2000 + 11'd1;
    tick_st.t3000 = (st_r.t3000 == ph3000_t'(PER_3000 - 1)) ? '0 : st_r.t3000 + 12'd1;
    tick_st.t4000 = (st_r.t4000 == ph4000_t'(PER_4000 - 1)) ? '0 : st_r.t4000 + 12'd1;
    tick_st.t5000 = (st_r.t5000 == ph5000_t'(PER_5000 - 1)) ? '0 : st_r.t5000 + 13'd1;
    tick_st.flash = (st_r.flash != 8'd0) ? st_r.flash - 8'd1 : 8'd0;
  end

  assign id_ok = (state_id < 4'(NUM_STATUS));

  // State after the command.
  always_comb begin
    st_nxt = st_r;
    case (command)
      CMD_TICK: begin
        st_nxt = tick_st;
      end
      CMD_SET: begin
        if (id_ok) begin
          st_nxt.mask = st_r.mask | (14'd1 << state_id);
        end
      end
      CMD_CLEAR: begin
        if (id_ok) begin
          st_nxt.mask = st_r.mask & ~(14'd1 << state_id);
        end
      end
      CMD_FLASH: begin
        st_nxt.flash = flash_len_r;
      end
      default: begin
        st_nxt = st_r;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  // Flash length register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flash_len_r <= FLASH_LEN_RESET;
    end else if (cfg_we) begin
      flash_len_r <= cfg_wdata;
    end
  end

endmodule

@@ rtl/slpg_pattern.sv @@
// ----------------------------------------------------------------------------
// slpg_pattern: priority selection and pattern lookup
// Picks the status shown, then derives its colour and brightness from the
// phase counters. Breathing ramps use a constant reciprocal multiply.
// ----------------------------------------------------------------------------
module slpg_pattern (
  input  slpg_pkg::slpg_state_t  st,
  input  logic [3:0]             state_id,
  output slpg_pkg::slpg_result_t res
);
  import slpg_pkg::*;

  logic [3:0]  shown;
  logic [2:0]  base_col;
  logic [2:0]  col;
  logic [7:0]  bright;
  logic [10:0] boot_d;
  logic [10:0] setup_d;
  logic [31:0] boot_prod;
  logic [28:0] setup_prod;

  // Winning status: a running flash first, then the highest set mask bit.
  always_comb begin
    shown = ST_OFF;
    for (int i = 1; i < NUM_STATUS; i++) begin
      if (st.mask[i]) begin
        shown = 4'(i);
      end
    end
    if (st.flash != 8'd0) begin
      shown = ST_DETECTION;
    end
  end

  // Colour under the offline blink.
  always_comb begin
    if (st.mask[ST_ARMED]) begin
      base_col = C_GREEN;
    end else if (st.mask[ST_DISARMED]) begin
      base_col = C_YELLOW;
    end else if (st.mask[ST_UNCLAIMED]) begin
      base_col = C_ORANGE;
    end else if (st.mask[ST_WIFI]) begin
      base_col = C_BLUE;
    end else if (st.mask[ST_SETUP]) begin
      base_col = C_CYAN;
    end else if (st.mask[ST_BOOT]) begin
      base_col = C_BLUE;
    end else begin
      base_col = C_OFF;
    end
  end

  // Triangle ramps: distance from the nearest period edge, scaled to 255.
  assign boot_d     = (st.t2000 < 11'(PER_2000 / 2)) ? st.t2000
                                                     : 11'(PER_2000) - st.t2000;
  assign setup_d    = (st.t3000 < 12'(PER_3000 / 2)) ? st.t3000[10:0]
                                                     : 11'(12'(PER_3000) - st.t3000);
  assign boot_prod  = 32'(boot_d) * BOOT_RECIP;
  assign setup_prod = 29'(setup_d) * SETUP_RECIP;

  // Pattern of the shown status.
  always_comb begin
    bright = FULL_BRIGHT;
    col    = C_OFF;
    case (shown)
      ST_BOOT: begin
        col    = C_BLUE;
        bright = boot_prod[31:24];
      end
      ST_SETUP: begin
        col    = C_CYAN;
        bright = setup_prod[27:20];
      end
      ST_WIFI: begin
        col = (st.t400 < 9'd200) ? C_BLUE : C_OFF;
      end
      ST_UNCLAIMED: begin
        col = ((st.t2000 < 11'd150) || (st.t2000 >= 11'd300 && st.t2000 < 11'd450))
              ? C_ORANGE : C_OFF;
      end
      ST_DISARMED: begin
        col = (st.t5000 >= 13'd4800) ? C_OFF : C_YELLOW;
      end
      ST_ARMED: begin
        col = C_GREEN;
      end
      ST_OFFLINE: begin
        col = (st.t4000 < 12'd100) ? C_ORANGE : base_col;
      end
      ST_AUTH_FAIL: begin
        col = (st.t500 < 9'd250) ? C_RED : C_ORANGE;
      end
      ST_DETECTION: begin
        col = C_WHITE;
      end
      ST_CAMERA: begin
        col = ((st.t1000 < 10'd100) || (st.t1000 >= 10'd200 && st.t1000 < 10'd300))
              ? C_RED : C_OFF;
      end
      ST_SERVO: begin
        col = ((st.t1250 < 11'd80) ||
               (st.t1250 >= 11'd160 && st.t1250 < 11'd240) ||
               (st.t1250 >= 11'd320 && st.t1250 < 11'd400)) ? C_RED : C_OFF;
      end
      ST_LASER: begin
        col = ((st.t1500 < 11'd60) ||
               (st.t1500 >= 11'd120 && st.t1500 < 11'd180) ||
               (st.t1500 >= 11'd240 && st.t1500 < 11'd300) ||
               (st.t1500 >= 11'd360 && st.t1500 < 11'd420)) ? C_RED : C_OFF;
      end
      ST_ERROR: begin
        col = (st.t1000 < 10'd500) ? C_RED : C_OFF;
      end
      default: begin
        col = C_OFF;
      end
    endcase
  end

  // Assemble the result; an unlit colour always has zero brightness.
  always_comb begin
    res.shown_state    = shown;
    res.color_code     = col;
    res.brightness     = (col == C_OFF) ? 8'd0 : bright;
    res.queried_active = (state_id < 4'(NUM_STATUS)) && st.mask[state_id];
  end

endmodule

@@ rtl/status_led_pattern_generator_unit.sv @@
// ----------------------------------------------------------------------------
// status_led_pattern_generator_unit: status LED pattern generator
// Each accepted request (tick, set, clear, flash or query) updates the status
// mask, millisecond time or flash countdown and yields one result in the next
// cycle: the status shown, its colour code and brightness, and the queried
// mask bit. The block takes one request per clock cycle; the result register
// frees itself in the same cycle it is read, so in_ready stays high while
// out_ready is high. The result is held in the single result register behind
// the pattern logic. The flash length register may be written at any
// time through cfg_we and cfg_wdata and applies to the next flash request.
// ----------------------------------------------------------------------------
module status_led_pattern_generator_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_command,
  input  logic [3:0] in_state_id,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_shown_state,
  output logic [2:0] out_color_code,
  output logic [7:0] out_brightness,
  output logic       out_queried_active,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import slpg_pkg::*;

  logic         accept;
  logic         out_valid_r;
  slpg_state_t  st_nxt;
  slpg_result_t res;
  slpg_result_t res_r;

  // Accept while the result register is empty or is being read.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  slpg_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .command   (in_command),
    .state_id  (in_state_id),
    .st_nxt    (st_nxt)
  );

  slpg_pattern u_pattern (
    .st       (st_nxt),
    .state_id (in_state_id),
    .res      (res)
  );

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_shown_state    = res_r.shown_state;
  assign out_color_code     = res_r.color_code;
  assign out_brightness     = res_r.brightness;
  assign out_queried_active = res_r.queried_active;

endmodule

@@ sim/slpg_led_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slpg_led_checker: result checker for the status LED pattern generator
// Watches the request, result and flash length ports. Keeps its own copy of
// the status mask, millisecond time and flash countdown. Works out the LED
// state due for every accepted request and compares each accepted result,
// field by field, with the oldest one still due.
// ----------------------------------------------------------------------------
module slpg_led_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [3:0]  in_state_id,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  out_shown_state,
  input  logic [2:0]  out_color_code,
  input  logic [7:0]  out_brightness,
  input  logic        out_queried_active,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  output int unsigned fail_count,
  output int unsigned pending
);
  import slpg_pkg::*;

  // The millisecond count runs from 0 to one below this value.
  localparam int unsigned TIME_WRAP = 60000;
  // Printing stops after this many errors; counting goes on.
  localparam int unsigned PRINT_LIMIT = 50;

  logic [NUM_STATUS-1:0] status_mask;
  logic [15:0]           now_ms;
  logic [7:0]            flash_left;
  logic [7:0]            flash_len;
  slpg_result_t          due_leds[$];
  slpg_result_t          want;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_error(input string msg);
    if (fail_count < PRINT_LIMIT) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
    fail_count++;
  endtask

  task automatic check_field(input string name, input int got, input int exp_val);
    if (got !== exp_val) begin
      report_error($sformatf("%s is %0d, expected %0d", name, got, exp_val));
    end
  endtask

  // Triangle ramp from 0 up to full brightness and back over one period.
  function automatic logic [7:0] ramp_level(input int unsigned t, input int unsigned period);
    int unsigned pos;
    int unsigned half;
    pos  = t % period;
    half = period / 2;
    if (pos < half) begin
      return 8'((pos * FULL_BRIGHT) / half);
    end
    return 8'(((period - pos) * FULL_BRIGHT) / half);
  endfunction

  // Colour that offline falls back to outside its orange flash.
  function automatic logic [2:0] base_colour();
    if (status_mask[ST_ARMED]) return C_GREEN;
    if (status_mask[ST_DISARMED]) return C_YELLOW;
    if (status_mask[ST_UNCLAIMED]) return C_ORANGE;
    if (status_mask[ST_WIFI]) return C_BLUE;
    if (status_mask[ST_SETUP]) return C_CYAN;
    if (status_mask[ST_BOOT]) return C_BLUE;
    return C_OFF;
  endfunction

  // LED state for the current mask, time and flash, plus the queried bit.
  function automatic slpg_result_t led_for_status(input logic [3:0] id);
    slpg_result_t res;
    int unsigned  t;
    int unsigned  p;
    int           s;
    logic [3:0]   shown;
    logic [2:0]   colour;
    logic [7:0]   level;
    t      = now_ms;
    level  = FULL_BRIGHT;
    colour = C_OFF;
    shown  = ST_OFF;
    // A running flash wins; otherwise the highest set status bit.
    if (flash_left != 0) begin
      shown = ST_DETECTION;
    end else begin
      for (s = ST_BOOT; s <= ST_ERROR; s++) begin
        if (status_mask[s]) shown = 4'(s);
      end
    end
    case (shown)
      ST_BOOT: begin
        level  = ramp_level(t, PER_2000);
        colour = C_BLUE;
      end
      ST_SETUP: begin
        level  = ramp_level(t, PER_3000);
        colour = C_CYAN;
      end
      ST_WIFI: colour = ((t % PER_400) < 200) ? C_BLUE : C_OFF;
      ST_UNCLAIMED: begin
        p = t % PER_2000;
        colour = (p < 150 || (p >= 300 && p < 450)) ? C_ORANGE : C_OFF;
      end
      ST_DISARMED: colour = ((t % PER_5000) >= 4800) ? C_OFF : C_YELLOW;
      ST_ARMED: colour = C_GREEN;
      ST_OFFLINE: colour = ((t % PER_4000) < 100) ? C_ORANGE : base_colour();
      ST_AUTH_FAIL: colour = ((t % PER_500) < 250) ? C_RED : C_ORANGE;
      ST_DETECTION: colour = C_WHITE;
      ST_CAMERA: begin
        p = t % PER_1000;
        colour = (p < 100 || (p >= 200 && p < 300)) ? C_RED : C_OFF;
      end
      ST_SERVO: begin
        p = t % PER_1250;
        colour = (p < 80 || (p >= 160 && p < 240) || (p >= 320 && p < 400)) ? C_RED : C_OFF;
      end
      ST_LASER: begin
        p = t % PER_1500;
        colour = (p < 60 || (p >= 120 && p < 180) || (p >= 240 && p < 300) ||
                  (p >= 360 && p < 420)) ? C_RED : C_OFF;
      end
      ST_ERROR: colour = ((t % PER_1000) < 500) ? C_RED : C_OFF;
      default: colour = C_OFF;
    endcase
    if (colour == C_OFF) level = '0;
    res.shown_state    = shown;
    res.color_code     = colour;
    res.brightness     = level;
    res.queried_active = (id < NUM_STATUS) ? status_mask[id] : 1'b0;
    return res;
  endfunction

  // Apply one request to the local state.
  task automatic apply_request(input logic [2:0] cmd, input logic [3:0] id);
    case (cmd)
      CMD_TICK: begin
        now_ms = (now_ms == TIME_WRAP - 1) ? '0 : now_ms + 1'b1;
        if (flash_left != 0) flash_left = flash_left - 1'b1;
      end
      CMD_SET: if (id < NUM_STATUS) status_mask[id] = 1'b1;
      CMD_CLEAR: if (id < NUM_STATUS) status_mask[id] = 1'b0;
      CMD_FLASH: flash_left = flash_len;
      default: ;
    endcase
  endtask

  // Results are retired before the request of the same edge is queued, since
  // a result can never belong to the request accepted at that very edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      status_mask = '0;
      now_ms      = '0;
      flash_left  = '0;
      flash_len   = FLASH_LEN_RESET;
      due_leds.delete();
    end else begin
      if (cfg_we) flash_len = cfg_wdata;
      if (out_valid && out_ready) begin
        if (due_leds.size() == 0) begin
          report_error($sformatf("result with nothing due (state %0d colour %0d)",
                                 out_shown_state, out_color_code));
        end else begin
          want = due_leds.pop_front();
          check_field("shown_state", out_shown_state, want.shown_state);
          check_field("color_code", out_color_code, want.color_code);
          check_field("brightness", out_brightness, want.brightness);
          check_field("queried_active", out_queried_active, want.queried_active);
        end
      end
      if (in_valid && in_ready) begin
        apply_request(in_command, in_state_id);
        due_leds.push_back(led_for_status(in_state_id));
      end
    end
    pending = due_leds.size();
  end

endmodule

@@ sim/tb_status_led_pattern_generator_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_status_led_pattern_generator_unit: testbench of the LED pattern generator
// Sends a short directed set of requests and then random ones: sets, clears,
// flashes, queries, unused commands and short runs of ticks. The flash length
// is changed between phases, and the sides stall at random in some phases but
// not in the last part of the run. The checker does all comparing.
// ----------------------------------------------------------------------------
module tb_status_led_pattern_generator_unit;
  import slpg_pkg::*;

  // Highest command code; the ones above CMD_QUERY are unused.
  localparam logic [2:0] CMD_MAX = 3'd7;
  // Highest status id the field can carry; ids from NUM_STATUS up are ignored.
  localparam logic [3:0] ID_MAX = 4'd15;
  localparam int unsigned STEPS_PER_PHASE = 25;
  localparam int unsigned NUM_PHASES = 6;
  // Random steps in the last part, which runs without idling.
  localparam int unsigned TAIL_STEPS = 20;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [2:0] in_command;
  logic [3:0] in_state_id;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [3:0] out_shown_state;
  logic [2:0] out_color_code;
  logic [7:0] out_brightness;
  logic       out_queried_active;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  int unsigned mon_fails;
  int unsigned mon_pending;

  bit                    in_idle_on = 1'b0;
  bit                    out_idle_on = 1'b0;
  int unsigned           stall_left = 0;
  logic [NUM_STATUS-1:0] lit;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  status_led_pattern_generator_unit uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_state_id        (in_state_id),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_shown_state    (out_shown_state),
    .out_color_code     (out_color_code),
    .out_brightness     (out_brightness),
    .out_queried_active (out_queried_active),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  slpg_led_checker led_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_state_id        (in_state_id),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_shown_state    (out_shown_state),
    .out_color_code     (out_color_code),
    .out_brightness     (out_brightness),
    .out_queried_active (out_queried_active),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .fail_count         (mon_fails),
    .pending            (mon_pending)
  );

  // Result side: out_ready drops for random stalls while enabled.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (out_idle_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Present one request, hold it until accepted, then maybe leave a gap.
  task automatic send_request(input logic [2:0] cmd, input logic [3:0] id);
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_state_id <= id;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (cmd == CMD_SET && id < NUM_STATUS) lit[id] = 1'b1;
    if (cmd == CMD_CLEAR && id < NUM_STATUS) lit[id] = 1'b0;
    @(negedge clk);
    if (in_idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
  endtask

  // Let every due result come back before touching the flash length.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (mon_pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_flash_length(input logic [7:0] len);
    pause_until_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One random step: a run of ticks or a single request. Clears mostly hit
  // the highest lit status so lower priority patterns come to the front.
  task automatic random_step();
    int unsigned r;
    int unsigned run;
    int          s;
    logic [3:0]  id;
    logic [3:0]  top_id;
    r  = $urandom_range(0, 99);
    id = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, ID_MAX))
                                     : 4'($urandom_range(ST_BOOT, ST_ERROR));
    top_id = id;
    for (s = ST_OFF; s <= ST_ERROR; s++) begin
      if (lit[s]) top_id = 4'(s);
    end
    if (r < 40) begin
      run = $urandom_range(1, 8);
      repeat (run) send_request(CMD_TICK, 4'($urandom_range(0, ID_MAX)));
    end else if (r < 60) begin
      send_request(CMD_SET, id);
    end else if (r < 75) begin
      send_request(CMD_CLEAR, ($urandom_range(0, 9) < 7) ? top_id : id);
    end else if (r < 83) begin
      send_request(CMD_FLASH, id);
    end else if (r < 93) begin
      send_request(CMD_QUERY, id);
    end else begin
      send_request(3'($urandom_range(CMD_QUERY + 1, CMD_MAX)), id);
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned guard;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_command  = CMD_TICK;
    in_state_id = ST_OFF;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    lit         = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed requests on the reset flash length.
    send_request(CMD_QUERY, ST_OFF);
    send_request(CMD_SET, 4'(NUM_STATUS));
    send_request(CMD_QUERY, ID_MAX);
    send_request(CMD_CLEAR, ID_MAX);
    send_request(CMD_SET, ST_OFF);
    send_request(CMD_QUERY, ST_OFF);
    send_request(CMD_SET, ST_OFFLINE);
    send_request(CMD_TICK, ST_OFFLINE);
    send_request(CMD_SET, ST_ARMED);
    send_request(CMD_FLASH, ST_ARMED);
    send_request(CMD_TICK, ST_DETECTION);
    send_request(CMD_SET, ST_ERROR);
    send_request(CMD_CLEAR, ST_ERROR);
    send_request(CMD_CLEAR, ST_OFFLINE);
    send_request(3'(CMD_QUERY + 1), ST_ARMED);
    send_request(3'(CMD_QUERY + 2), 4'(NUM_STATUS));
    send_request(CMD_MAX, ID_MAX);
    send_request(CMD_SET, ST_BOOT);
    send_request(CMD_CLEAR, ST_ARMED);
    send_request(CMD_TICK, ST_BOOT);
    send_request(CMD_CLEAR, ST_OFF);

    // Random phases, each with its own flash length and idling.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          in_idle_on  = 1'b1;
          out_idle_on = 1'b1;
        end
        1: begin
          write_flash_length(8'd0);
          in_idle_on  = 1'b1;
          out_idle_on = 1'b0;
        end
        2: begin
          write_flash_length(8'd255);
          in_idle_on  = 1'b0;
          out_idle_on = 1'b1;
        end
        3: begin
          write_flash_length(8'd1);
          in_idle_on  = 1'b0;
          out_idle_on = 1'b0;
        end
        default: begin
          write_flash_length(8'($urandom_range(0, 255)));
          in_idle_on  = 1'b1;
          out_idle_on = 1'b1;
        end
      endcase
      repeat (STEPS_PER_PHASE) random_step();
    end

    // Last part without idling.
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    write_flash_length(8'($urandom_range(1, 255)));
    repeat (TAIL_STEPS) random_step();
    in_valid <= 1'b0;

    guard = 0;
    while (mon_pending != 0 && guard < 200) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);
    if (mon_pending != 0) begin
      $display("ERROR: %0d results never arrived", mon_pending);
    end
    if (mon_fails == 0 && mon_pending == 0) begin
      $display("status_led_pattern_generator_unit test passed");
    end else begin
      $display("status_led_pattern_generator_unit test failed");
    end
    $finish;
  end

  // Run time limit.
  initial begin
    #2_000_000;
    $display("status_led_pattern_generator_unit test failed");
    $finish;
  end

endmodule

@@ status_led_pattern_generator_unit.f @@
rtl/slpg_pkg.sv
rtl/slpg_state.sv
rtl/slpg_pattern.sv
rtl/status_led_pattern_generator_unit.sv
sim/slpg_led_checker.sv
sim/tb_status_led_pattern_generator_unit.sv
